// ----- src/tbc_pkg.sv -----
`default_nettype none
package tbc_pkg;

   localparam int unsigned SAMPLE_MAX = 8192;
   localparam int unsigned CNT_W      = $clog2(SAMPLE_MAX + 1);
   localparam int unsigned MUL_W      = CNT_W + 8;
   localparam int unsigned FIELD_W    = 14;
   localparam int unsigned LIMIT_W    = 7;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd2;
   localparam logic [7:0]         PCT_SCALE   = 8'd100;

   localparam logic [7:0] CTRL_BOUND = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] HIGH_BIT   = 8'h80;
   localparam logic [7:0] MASK_2     = 8'hC0;
   localparam logic [7:0] MASK_3     = 8'hE0;
   localparam logic [7:0] MASK_4     = 8'hF0;
   localparam logic [7:0] MASK_5     = 8'hF8;
   localparam logic [7:0] LEAD_2     = 8'hC0;
   localparam logic [7:0] LEAD_3     = 8'hE0;
   localparam logic [7:0] LEAD_4     = 8'hF0;
   localparam logic [7:0] CONT_BITS  = 8'h80;

   typedef enum logic [1:0] {
      REASON_TEXT      = 2'd0,
      REASON_LOW_CTRL  = 2'd1,
      REASON_NULL_BYTE = 2'd2,
      REASON_HIGH_CTRL = 2'd3
   } reason_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic               is_binary;
      reason_type         verdict_reason;
      logic [FIELD_W-1:0] control_count;
      logic [FIELD_W-1:0] byte_count;
   } rsp_type;

   typedef struct packed {
      logic             null_seen;
      logic             utf8_failed;
      logic [CNT_W-1:0] ctrl_cnt;
      logic [CNT_W-1:0] byte_cnt;
   } snap_type;

endpackage
`default_nettype wire

// ----- src/tbc_sample_tracker.sv -----
`default_nettype none
module tbc_sample_tracker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire tbc_pkg::req_type  in_item,
   output logic                   in_ready,
   output logic                   snap_valid,
   output tbc_pkg::snap_type      snap,
   input  wire logic              snap_take
);

   logic                      null_ff, null_in;
   logic                      fail_ff, fail_in;
   logic [1:0]                cont_ff, cont_in;
   logic                      bad_ff, bad_in;
   logic [tbc_pkg::CNT_W-1:0] ctrl_ff, ctrl_in;
   logic [tbc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      snap_valid_ff, snap_valid_in;
   tbc_pkg::snap_type         snap_ff, snap_in;

   logic                      consume;
   logic                      take;
   logic [7:0]                b;
   logic                      u_null, u_fail, u_bad;
   logic [1:0]                u_cont;
   logic [tbc_pkg::CNT_W-1:0] u_ctrl, u_cnt;

   assign in_ready = !snap_valid_ff || snap_take || !in_item.last;
   assign consume  = in_valid && in_ready;
   assign b        = in_item.data_byte;
   assign take     = consume && in_item.has_byte
                     && (cnt_ff < tbc_pkg::CNT_W'(tbc_pkg::SAMPLE_MAX));

   always_comb begin
      u_null = null_ff;
      u_fail = fail_ff;
      u_cont = cont_ff;
      u_bad  = bad_ff;
      u_ctrl = ctrl_ff;
      u_cnt  = cnt_ff;
      if (take) begin
         u_cnt = cnt_ff + 1'b1;
         if (b == 8'h00) begin
            u_null = 1'b1;
         end
         if (b < tbc_pkg::CTRL_BOUND && b != tbc_pkg::CHAR_TAB
             && b != tbc_pkg::CHAR_LF && b != tbc_pkg::CHAR_CR) begin
            u_ctrl = ctrl_ff + 1'b1;
         end
         if (cont_ff != 2'd0) begin
            // close the sequence on its final continuation
            u_cont = cont_ff - 2'd1;
            u_bad  = bad_ff || ((b & tbc_pkg::MASK_2) != tbc_pkg::CONT_BITS);
            if (u_cont == 2'd0) begin
               u_fail = fail_ff || u_bad;
               u_bad  = 1'b0;
            end
         end else if ((b & tbc_pkg::HIGH_BIT) != 8'h00) begin
            if ((b & tbc_pkg::MASK_3) == tbc_pkg::LEAD_2) begin
               u_cont = 2'd1;
            end else if ((b & tbc_pkg::MASK_4) == tbc_pkg::LEAD_3) begin
               u_cont = 2'd2;
            end else if ((b & tbc_pkg::MASK_5) == tbc_pkg::LEAD_4) begin
               u_cont = 2'd3;
            end else begin
               u_fail = 1'b1;
            end
         end
      end
   end

   always_comb begin
      null_in = null_ff;
      fail_in = fail_ff;
      cont_in = cont_ff;
      bad_in  = bad_ff;
      ctrl_in = ctrl_ff;
      cnt_in  = cnt_ff;
      snap_in = snap_ff;
      snap_valid_in = snap_valid_ff && !snap_take;
      if (consume) begin
         if (in_item.last) begin
            // hand the finished sample on and start a fresh one
            snap_in.null_seen   = u_null;
            snap_in.utf8_failed = u_fail;
            snap_in.ctrl_cnt    = u_ctrl;
            snap_in.byte_cnt    = u_cnt;
            snap_valid_in = 1'b1;
            null_in = 1'b0;
            fail_in = 1'b0;
            cont_in = 2'd0;
            bad_in  = 1'b0;
            ctrl_in = '0;
            cnt_in  = '0;
         end else begin
            null_in = u_null;
            fail_in = u_fail;
            cont_in = u_cont;
            bad_in  = u_bad;
            ctrl_in = u_ctrl;
            cnt_in  = u_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         null_ff       <= 1'b0;
         fail_ff       <= 1'b0;
         cont_ff       <= 2'd0;
         bad_ff        <= 1'b0;
         ctrl_ff       <= '0;
         cnt_ff        <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         null_ff       <= null_in;
         fail_ff       <= fail_in;
         cont_ff       <= cont_in;
         bad_ff        <= bad_in;
         ctrl_ff       <= ctrl_in;
         cnt_ff        <= cnt_in;
         snap_valid_ff <= snap_valid_in;
      end
      snap_ff <= snap_in;
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule
`default_nettype wire

// ----- src/tbc_verdict.sv -----
`default_nettype none
module tbc_verdict (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        snap_valid,
   input  wire tbc_pkg::snap_type           snap,
   output logic                             snap_take,
   input  wire logic [tbc_pkg::LIMIT_W-1:0] limit,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output tbc_pkg::rsp_type                 rsp_data
);

   logic                      rsp_valid_ff, rsp_valid_in;
   tbc_pkg::rsp_type          rsp_ff, rsp_in;
   logic [tbc_pkg::MUL_W-1:0] lhs, rhs;
   logic [7:0]                limit_p1;

   assign snap_take = snap_valid && (!rsp_valid_ff || rsp_ready);
   assign limit_p1  = 8'(limit) + 8'd1;
   assign lhs = tbc_pkg::MUL_W'(snap.ctrl_cnt) * tbc_pkg::MUL_W'(tbc_pkg::PCT_SCALE);
   assign rhs = tbc_pkg::MUL_W'(limit_p1) * tbc_pkg::MUL_W'(snap.byte_cnt);

   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (snap_take) begin
         rsp_valid_in = 1'b1;
         rsp_in.control_count = tbc_pkg::FIELD_W'(snap.ctrl_cnt);
         rsp_in.byte_count    = tbc_pkg::FIELD_W'(snap.byte_cnt);
         if (snap.byte_cnt == '0) begin
            rsp_in.is_binary      = 1'b0;
            rsp_in.verdict_reason = tbc_pkg::REASON_TEXT;
         end else if (snap.null_seen) begin
            rsp_in.is_binary      = 1'b1;
            rsp_in.verdict_reason = tbc_pkg::REASON_NULL_BYTE;
         end else if (!snap.utf8_failed) begin
            rsp_in.is_binary      = 1'b0;
            rsp_in.verdict_reason = tbc_pkg::REASON_TEXT;
         end else if (lhs >= rhs) begin
            rsp_in.is_binary      = 1'b1;
            rsp_in.verdict_reason = tbc_pkg::REASON_HIGH_CTRL;
         end else begin
            rsp_in.is_binary      = 1'b0;
            rsp_in.verdict_reason = tbc_pkg::REASON_LOW_CTRL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ----- src/text_binary_classifier.sv -----
// A verdict passes the input register, the sample tracker snapshot and the verdict register after the last item.
// Throughput: one item per cycle; the input register, the sample tracker and the
// verdict register advance independently, so only a stalled result holds input.
// Reset (synchronous, active high) empties the pipeline, clears the sample state
// and sets the control percent limit to 2.
`default_nettype none
module text_binary_classifier (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire tbc_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output tbc_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [tbc_pkg::LIMIT_W-1:0] csr_wr_data
);

   logic                        a_valid_ff, a_valid_in;
   tbc_pkg::req_type            a_data_ff, a_data_in;
   logic [tbc_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic                        trk_ready;
   logic                        snap_valid;
   tbc_pkg::snap_type           snap;
   logic                        snap_take;
   logic                        req_xfer;

   assign req_ready  = !a_valid_ff || trk_ready;
   assign req_xfer   = req_valid && req_ready;
   assign a_valid_in = req_xfer || (a_valid_ff && !trk_ready);
   assign a_data_in  = req_xfer ? req_data : a_data_ff;
   assign limit_in   = csr_wr_en ? csr_wr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         limit_ff   <= tbc_pkg::LIMIT_RESET;
      end else begin
         a_valid_ff <= a_valid_in;
         limit_ff   <= limit_in;
      end
      a_data_ff <= a_data_in;
   end

   tbc_sample_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (a_valid_ff),
      .in_item    (a_data_ff),
      .in_ready   (trk_ready),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_take  (snap_take)
   );

   tbc_verdict u_verdict (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_take  (snap_take),
      .limit      (limit_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   a_binary_matches_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.is_binary ==
         (rsp_data.verdict_reason == tbc_pkg::REASON_NULL_BYTE ||
          rsp_data.verdict_reason == tbc_pkg::REASON_HIGH_CTRL))
      else $error("is_binary disagrees with verdict_reason");

   a_ctrl_within_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.control_count <= rsp_data.byte_count)
      else $error("control count exceeds byte count");

   a_empty_is_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_count == '0 |->
         rsp_data.verdict_reason == tbc_pkg::REASON_TEXT)
      else $error("empty sample not reported as text");

   a_snapshot_held: assert property (@(posedge clock) disable iff (reset)
      snap_valid && !snap_take |=> snap_valid && $stable(snap))
      else $error("finished sample dropped before verdict");

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   tbc_pkg::req_type            req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   tbc_pkg::rsp_type            rsp_data;
   logic                        csr_wr_en = 1'b0;
   logic [tbc_pkg::LIMIT_W-1:0] csr_wr_data = '0;

   tbc_pkg::req_type            item_q[$];
   tbc_pkg::rsp_type            verdict_q[$];
   int                          queued = 0;
   int                          errs = 0;
   bit                          no_gaps = 1'b0;

   // sample tracker state and register copy
   logic [tbc_pkg::LIMIT_W-1:0] ctl_limit = tbc_pkg::LIMIT_RESET;
   bit                          smp_null = 1'b0;
   bit                          utf8_bad = 1'b0;
   logic [1:0]                  cont_left = '0;
   bit                          seq_bad = 1'b0;
   int                          smp_ctrl = 0;
   int                          smp_bytes = 0;

   text_binary_classifier u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic classify_item(input tbc_pkg::req_type it);
      tbc_pkg::rsp_type v;
      logic [7:0]       b;
      b = it.data_byte;
      if (it.has_byte && smp_bytes < tbc_pkg::SAMPLE_MAX) begin
         smp_bytes++;
         if (b == 8'h00)
            smp_null = 1'b1;
         if (b < tbc_pkg::CTRL_BOUND && b != tbc_pkg::CHAR_TAB && b != tbc_pkg::CHAR_LF
             && b != tbc_pkg::CHAR_CR)
            smp_ctrl++;
         if (cont_left != 0) begin
            if ((b & tbc_pkg::MASK_2) != tbc_pkg::CONT_BITS)
               seq_bad = 1'b1;
            cont_left--;
            if (cont_left == 0) begin
               if (seq_bad)
                  utf8_bad = 1'b1;
               seq_bad = 1'b0;
            end
         end else if (b >= tbc_pkg::HIGH_BIT) begin
            if ((b & tbc_pkg::MASK_3) == tbc_pkg::LEAD_2)
               cont_left = 2'd1;
            else if ((b & tbc_pkg::MASK_4) == tbc_pkg::LEAD_3)
               cont_left = 2'd2;
            else if ((b & tbc_pkg::MASK_5) == tbc_pkg::LEAD_4)
               cont_left = 2'd3;
            else
               utf8_bad = 1'b1;
         end
      end
      if (!it.last)
         return;
      v.is_binary = 1'b0;
      v.verdict_reason = tbc_pkg::REASON_TEXT;
      if (smp_bytes == 0) begin
         v.verdict_reason = tbc_pkg::REASON_TEXT;
      end else if (smp_null) begin
         v.is_binary = 1'b1;
         v.verdict_reason = tbc_pkg::REASON_NULL_BYTE;
      end else if (utf8_bad) begin
         if (longint'(smp_ctrl) * 100 >=
             (longint'(ctl_limit) + 1) * longint'(smp_bytes)) begin
            v.is_binary = 1'b1;
            v.verdict_reason = tbc_pkg::REASON_HIGH_CTRL;
         end else begin
            v.verdict_reason = tbc_pkg::REASON_LOW_CTRL;
         end
      end
      v.control_count = tbc_pkg::FIELD_W'(smp_ctrl);
      v.byte_count = tbc_pkg::FIELD_W'(smp_bytes);
      verdict_q.push_back(v);
      smp_null = 1'b0;
      utf8_bad = 1'b0;
      cont_left = '0;
      seq_bad = 1'b0;
      smp_ctrl = 0;
      smp_bytes = 0;
   endtask

   // driver: advance to the next pending item after each transfer
   always @(posedge clock) begin : drv
      bit fire;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fire = req_valid && req_ready;
         if (fire)
            classify_item(req_data);
         if (!req_valid || fire) begin
            if (item_q.size() != 0 && (no_gaps || $urandom_range(99) >= 14)) begin
               req_valid <= 1'b1;
               req_data <= item_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errs++;
      end
   endtask

   always @(posedge clock) begin : mon
      tbc_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $error("verdict with none pending: %p", rsp_data);
               errs++;
            end else begin
               want = verdict_q.pop_front();
               check_field("is_binary", want.is_binary, rsp_data.is_binary);
               check_field("verdict_reason", want.verdict_reason, rsp_data.verdict_reason);
               check_field("control_count", want.control_count, rsp_data.control_count);
               check_field("byte_count", want.byte_count, rsp_data.byte_count);
            end
         end
         rsp_ready <= no_gaps || ($urandom_range(99) >= 14);
      end
   end

   task automatic put(input logic hb, input logic [7:0] b, input logic lst);
      item_q.push_back('{has_byte: hb, data_byte: b, last: lst});
      if (hb || lst)
         queued++;
   endtask

   function automatic logic [7:0] ctrl_byte();
      logic [7:0] c;
      do
         c = 8'($urandom_range(1, 31));
      while (c == tbc_pkg::CHAR_TAB || c == tbc_pkg::CHAR_LF || c == tbc_pkg::CHAR_CR);
      return c;
   endfunction

   // clean UTF-8 most of the time, then broken sequences, noise and empty samples
   task automatic random_sample();
      logic [7:0] sb[$];
      int         kind, chars, cap, ctrl_pct, r, pos, n_cont;
      bit         tail_alone;
      kind = $urandom_range(99);
      if (kind < 92) begin
         chars = $urandom_range(1, 24);
         cap = 2 * int'(ctl_limit) + 6;
         ctrl_pct = $urandom_range(0, cap > 100 ? 100 : cap);
         if (kind < 55 && $urandom_range(1))
            ctrl_pct = 0;
         for (int i = 0; i < chars; i++) begin
            r = $urandom_range(99);
            n_cont = 0;
            if (kind >= 80) begin
               sb.push_back(8'($urandom_range(255)));
            end else if ($urandom_range(99) < ctrl_pct) begin
               sb.push_back(ctrl_byte());
            end else if (r < 55) begin
               sb.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end else if (r < 62) begin
               sb.push_back(r < 58 ? tbc_pkg::CHAR_TAB
                                   : (r < 60 ? tbc_pkg::CHAR_LF : tbc_pkg::CHAR_CR));
            end else if (r < 77) begin
               sb.push_back(8'($urandom_range(8'hC2, 8'hDF)));
               n_cont = 1;
            end else if (r < 90) begin
               sb.push_back(8'($urandom_range(8'hE0, 8'hEF)));
               n_cont = 2;
            end else begin
               sb.push_back(8'($urandom_range(8'hF0, 8'hF7)));
               n_cont = 3;
            end
            for (int k = 0; k < n_cont; k++)
               sb.push_back(8'($urandom_range(8'h80, 8'hBF)));
         end
         if (kind >= 55 && kind < 80) begin
            pos = $urandom_range(sb.size() - 1);
            case ($urandom_range(2))
               0: sb[pos] = 8'($urandom_range(8'hF8, 8'hFF));
               1: sb[pos] = 8'($urandom_range(8'h80, 8'hBF));
               default: sb.insert(pos, 8'($urandom_range(8'hC0, 8'hF7)));
            endcase
         end
         if ($urandom_range(99) < 5)
            sb[$urandom_range(sb.size() - 1)] = 8'h00;
         // drop the final byte now and then, which may cut a trailing sequence short
         if ($urandom_range(99) < 10)
            void'(sb.pop_back());
      end
      tail_alone = (sb.size() == 0) || ($urandom_range(99) < 25);
      foreach (sb[i]) begin
         if ($urandom_range(99) < 4)
            put(1'b0, 8'($urandom_range(255)), 1'b0);
         put(1'b1, sb[i], !tail_alone && i == sb.size() - 1);
      end
      if (tail_alone)
         put(1'b0, 8'($urandom_range(255)), 1'b1);
   endtask

   // hold the sender until every verdict is in and the pipeline has emptied
   task automatic drain();
      do
         @(negedge clock);
      while (item_q.size() != 0 || req_valid || verdict_q.size() != 0);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_limit(input logic [tbc_pkg::LIMIT_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      ctl_limit = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [tbc_pkg::LIMIT_W-1:0] limits[5];
      logic [7:0]                  b;
      int                          target;
      limits = '{7'd0, 7'd100, 7'd27, 7'd50, 7'd0};

      // empty sample
      put(1'b0, 8'hA5, 1'b1);
      // null byte
      put(1'b1, 8'h41, 1'b0); put(1'b1, 8'h00, 1'b1);
      // two, three and four byte sequences, with an empty item inside one
      put(1'b1, 8'hC3, 1'b0); put(1'b1, 8'hA9, 1'b0);
      put(1'b1, 8'hE2, 1'b0); put(1'b1, 8'h82, 1'b0); put(1'b1, 8'hAC, 1'b0);
      put(1'b1, 8'hF0, 1'b0); put(1'b1, 8'h9F, 1'b0); put(1'b0, 8'h5A, 1'b0);
      put(1'b1, 8'h98, 1'b0); put(1'b1, 8'h80, 1'b1);
      // bad lead, control bytes over the limit
      put(1'b1, 8'hFF, 1'b0); put(1'b1, 8'h01, 1'b0); put(1'b1, 8'h1F, 1'b1);
      // malformed continuation left open at the end
      put(1'b1, 8'hE2, 1'b0); put(1'b1, 8'h41, 1'b1);
      // tab, LF and CR not counted; malformed sequence completed on the final byte
      put(1'b1, 8'h09, 1'b0); put(1'b1, 8'h0A, 1'b0); put(1'b1, 8'h0D, 1'b0);
      put(1'b1, 8'hC3, 1'b0); put(1'b1, 8'h41, 1'b1);
      // lowest bad lead above the four byte leads
      put(1'b1, 8'h7F, 1'b0); put(1'b1, 8'hF8, 1'b1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      drain();

      // one sample past the byte limit, a lead open right at the cutoff
      for (int i = 0; i < tbc_pkg::SAMPLE_MAX + 100; i++) begin
         if (i == 5)
            b = 8'hFF;
         else if (i == tbc_pkg::SAMPLE_MAX - 1)
            b = tbc_pkg::LEAD_3;
         else if (i >= tbc_pkg::SAMPLE_MAX)
            b = 8'($urandom_range(255));
         else if ($urandom_range(99) < 3)
            b = ctrl_byte();
         else
            b = 8'($urandom_range(8'h20, 8'h7E));
         put(1'b1, b, i == tbc_pkg::SAMPLE_MAX + 99);
      end
      drain();

      for (int p = 0; p < 5; p++) begin
         write_limit(p == 4 ? tbc_pkg::LIMIT_W'($urandom_range(100)) : limits[p]);
         no_gaps = (p == 2);
         target = queued + 220;
         while (queued < target)
            random_sample();
         drain();
      end
      no_gaps = 1'b0;

      for (int c = 0; c < 5000 && verdict_q.size() != 0; c++)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (verdict_q.size() != 0) begin
         $error("%0d verdicts never arrived", verdict_q.size());
         errs++;
      end
      if (errs == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire
